@@ hdl/windowed_byte_entropy_macros.svh @@
// Assertion macros shared by the checker of the windowed byte entropy block.
// No dependencies.
`ifndef WINDOWED_BYTE_ENTROPY_MACROS_SVH
`define WINDOWED_BYTE_ENTROPY_MACROS_SVH

// next-cycle implication, gated by reset
`define WBE_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("windowed_byte_entropy assertion failed");

// next-cycle implication that also holds across reset
`define WBE_ASSERT_ALWAYS_NEXT(lbl, clk, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("windowed_byte_entropy assertion failed");

`endif

@@ hdl/wbe_pkg.sv @@
// Shared types and constants of the windowed byte entropy block.
// No dependencies.
package wbe_pkg;

  localparam int DATA_W = 8;
  localparam int NBINS  = 256;
  localparam int CFG_W  = 17;
  localparam int ENT_W  = 20;
  localparam int LEN_W  = 17;
  localparam int QF     = 32;

  localparam logic [CFG_W-1:0] BLOCK_SIZE_RST = 17'd4096;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              stream_end;
  } in_req_t;

  typedef struct packed {
    logic [ENT_W-1:0] entropy;
    logic [LEN_W-1:0] block_length;
    logic             final_block;
  } out_req_t;

endpackage

@@ hdl/wbe_log2.sv @@
// Iterative log2 unit, unsigned Q32 result, one result bit per cycle by squaring.
// Depends on wbe_pkg.
module wbe_log2 #(
  parameter int NW = 17
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [NW-1:0]                          n,
  output logic                                   done,
  output logic [$clog2(NW)+wbe_pkg::QF-1:0]      res
);
  import wbe_pkg::*;

  localparam int KW = $clog2(NW);
  localparam int LW = KW + QF;

  logic [30:0]    m_r;
  logic [KW-1:0]  k_r;
  logic [QF-1:0]  frac_r;
  logic [4:0]     bit_r;
  logic           run_r;
  logic           done_r;
  logic           zero_r;

  logic [KW-1:0]  k;
  logic [30:0]    m0;
  logic [61:0]    sq;
  logic [31:0]    sr;

  always_comb begin
    k = '0;
    for (int i = 0; i < NW; i++) begin
      if (n[i]) k = KW'(i);
    end
  end

  assign m0 = 31'(n) << (30 - int'(k));
  assign sq = m_r * m_r;
  assign sr = 32'((sq + (62'd1 << 29)) >> 30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && (bit_r == 5'd0);
      if (start && !run_r) begin
        m_r    <= m0;
        k_r    <= k;
        zero_r <= (n < NW'(2));
        frac_r <= '0;
        bit_r  <= 5'd31;
        run_r  <= 1'b1;
      end else if (run_r) begin
        frac_r[bit_r] <= sr[31];
        m_r           <= sr[31] ? sr[31:1] : sr[30:0];
        bit_r         <= bit_r - 5'd1;
        if (bit_r == 5'd0) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = zero_r ? '0 : LW'({k_r, frac_r});

endmodule

@@ hdl/wbe_queue.sv @@
// Two-entry queue between the histogram front and the entropy back.
// Depends on wbe_pkg.
module wbe_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  import wbe_pkg::*;

  logic [W-1:0] slot_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wp_r] <= wdata;
        wp_r         <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign rdata = slot_r[rp_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

endmodule

@@ hdl/wbe_front.sv @@
// Front part: takes bytes, keeps the histogram and the running sum of c*log2(c).
// Depends on wbe_pkg and wbe_log2; hands closed blocks to the queue.
module wbe_front #(
  parameter int MAX_BLOCK = 65536,
  parameter int CW        = 17,
  parameter int WW        = 54
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  wbe_pkg::in_req_t          in_req,
  input  logic                      cfg_we,
  input  logic [wbe_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [WW+CW:0]            q_wdata
);
  import wbe_pkg::*;

  localparam int KW = $clog2(CW);
  localparam int LW = KW + QF;
  localparam int SW = (CFG_W > CW) ? CFG_W : CW;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_LOG, S_MHI, S_UPD} state_t;

  state_t             state_r;
  logic [CFG_W-1:0]   win_len_r;
  logic [CW+WW-1:0]   bin_mem [NBINS];
  logic [NBINS-1:0]   valid_r;
  logic [CW+WW-1:0]   rd_r;
  logic               rd_vld_r;
  logic [DATA_W-1:0]  byte_r;
  logic               last_r;
  logic [CW-1:0]      c1_r;
  logic [WW-1:0]      old_r;
  logic [CW+QF-1:0]   prod_r;
  logic [KW-1:0]      hi_r;
  logic [WW-1:0]      clog_r;
  logic [WW-1:0]      wsum_r;
  logic [CW-1:0]      cnt_r;
  logic               q_push_r;
  logic [WW+CW:0]     q_wdata_r;

  logic               acc;
  logic [CW-1:0]      c_rd;
  logic               lg_start;
  logic               lg_done;
  logic [LW-1:0]      lg_res;
  logic [SW-1:0]      bs;
  logic [SW-1:0]      eff;
  logic [WW-1:0]      wsum_nxt;
  logic [CW-1:0]      cnt_nxt;
  logic               close;

  // a push in flight is not yet counted by the queue
  assign in_stall = !((state_r == S_IDLE) && !q_full && !q_push_r);
  assign acc      = in_valid && !in_stall;
  assign c_rd     = rd_vld_r ? rd_r[CW+WW-1:WW] : '0;
  assign lg_start = (state_r == S_READ);

  wbe_log2 #(.NW(CW)) u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lg_start),
    .n     (c_rd + CW'(1)),
    .done  (lg_done),
    .res   (lg_res)
  );

  always_comb begin
    bs = SW'(win_len_r);
    if (bs == '0) eff = SW'(1);
    else if (bs > SW'(MAX_BLOCK)) eff = SW'(MAX_BLOCK);
    else eff = bs;
  end

  assign wsum_nxt = wsum_r + clog_r - old_r;
  assign cnt_nxt  = cnt_r + CW'(1);
  assign close    = last_r || (SW'(cnt_nxt) >= eff);

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r <= bin_mem[in_req.data_byte];
    end
    if (state_r == S_UPD) begin
      bin_mem[byte_r] <= {c1_r, clog_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      win_len_r <= BLOCK_SIZE_RST;
      valid_r   <= '0;
      wsum_r    <= '0;
      cnt_r     <= '0;
      q_push_r  <= 1'b0;
    end else begin
      q_push_r <= (state_r == S_UPD) && close;
      if (cfg_we) win_len_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            byte_r   <= in_req.data_byte;
            last_r   <= in_req.stream_end;
            rd_vld_r <= valid_r[in_req.data_byte];
            state_r  <= S_READ;
          end
        end
        S_READ: begin
          c1_r    <= c_rd + CW'(1);
          old_r   <= rd_vld_r ? rd_r[WW-1:0] : '0;
          state_r <= S_LOG;
        end
        S_LOG: begin
          if (lg_done) begin
            prod_r  <= c1_r * lg_res[QF-1:0];
            hi_r    <= lg_res[LW-1:QF];
            state_r <= S_MHI;
          end
        end
        S_MHI: begin
          clog_r  <= WW'(prod_r) + ((WW'(c1_r) * WW'(hi_r)) << QF);
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (close) begin
            q_wdata_r <= {wsum_nxt, cnt_nxt, last_r};
            valid_r   <= '0;
            wsum_r    <= '0;
            cnt_r     <= '0;
          end else begin
            valid_r[byte_r] <= 1'b1;
            wsum_r          <= wsum_nxt;
            cnt_r           <= cnt_nxt;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign q_push  = q_push_r;
  assign q_wdata = q_wdata_r;

endmodule

@@ hdl/wbe_back.sv @@
// Back part: per closed block, log2 of the length and a long division, then rounding.
// Depends on wbe_pkg and wbe_log2; drives the result channel.
module wbe_back #(
  parameter int CW            = 17,
  parameter int WW            = 54,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic [WW+CW:0]     q_rdata,
  output logic               out_valid,
  input  logic               out_stall,
  output wbe_pkg::out_req_t  out_req
);
  import wbe_pkg::*;

  localparam int KW = $clog2(CW);
  localparam int LW = KW + QF;
  localparam int SH = QF - FRACTION_BITS;
  localparam int DW = $clog2(WW + 1);
  localparam logic [WW:0] ENT_MAX = (WW+1)'((64'd1 << ENT_W) - 64'd1);

  typedef enum logic {B_IDLE, B_RUN} state_t;

  state_t          state_r;
  logic [CW-1:0]   len_r;
  logic            last_r;
  logic [WW-1:0]   dvd_r;
  logic [CW-1:0]   rem_r;
  logic [DW-1:0]   dcnt_r;
  logic            lg_ok_r;
  logic [LW-1:0]   lg_r;
  logic            out_valid_r;
  out_req_t        out_req_r;

  logic            lg_start;
  logic            lg_done;
  logic [LW-1:0]   lg_res;
  logic [CW:0]     rem_sh;
  logic            qbit;
  logic [WW-1:0]   diff;
  logic [WW:0]     rnd;
  logic            slot_free;
  logic            finish;

  assign lg_start  = (state_r == B_IDLE) && !q_empty;
  assign q_pop     = lg_start;
  assign slot_free = !out_valid_r || !out_stall;
  assign finish    = (state_r == B_RUN) && lg_ok_r && (dcnt_r == '0) && slot_free;

  wbe_log2 #(.NW(CW)) u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lg_start),
    .n     (q_rdata[CW:1]),
    .done  (lg_done),
    .res   (lg_res)
  );

  assign rem_sh = {rem_r, dvd_r[WW-1]};
  assign qbit   = (rem_sh >= {1'b0, len_r});
  assign diff   = (WW'(lg_r) > dvd_r) ? (WW'(lg_r) - dvd_r) : '0;
  assign rnd    = ({1'b0, diff} + ((WW+1)'(1) << (SH - 1))) >> SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      lg_ok_r     <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      if (finish) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (lg_start) lg_ok_r <= 1'b0;
      else if (lg_done) lg_ok_r <= 1'b1;
      if (lg_done) lg_r <= lg_res;
      unique case (state_r)
        B_IDLE: begin
          if (lg_start) begin
            dvd_r   <= q_rdata[WW+CW:CW+1];
            len_r   <= q_rdata[CW:1];
            last_r  <= q_rdata[0];
            rem_r   <= '0;
            dcnt_r  <= DW'(WW);
            state_r <= B_RUN;
          end
        end
        B_RUN: begin
          if (dcnt_r != '0) begin
            rem_r  <= qbit ? CW'(rem_sh - {1'b0, len_r}) : rem_sh[CW-1:0];
            dvd_r  <= {dvd_r[WW-2:0], qbit};
            dcnt_r <= dcnt_r - DW'(1);
          end
          if (finish) begin
            out_req_r.entropy      <= (rnd > ENT_MAX) ? '1 : rnd[ENT_W-1:0];
            out_req_r.block_length <= LEN_W'(len_r);
            out_req_r.final_block  <= last_r;
            state_r                <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

@@ hdl/windowed_byte_entropy.sv @@
// Top level of the windowed byte entropy block: front, queue and back.
// Depends on wbe_pkg, wbe_front, wbe_queue, wbe_back.
//
// Counts bytes into a 256-bin histogram and, when a block closes (the configured
// window length in bytes, or a byte marked stream_end), returns its Shannon entropy
// in bits per byte with FRACTION_BITS fraction bits, plus the block length. Each
// byte passes through the front in order: one histogram read, the 32-step
// log2 unit that computes log2(count+1), the multiplies and the update, and the
// front takes no new byte until that update is done; a byte that closes a block
// also holds off the next byte while the block is pushed to the queue. A closed
// block is worked in the back by the one-bit-per-cycle divider; this overlaps the
// next block's bytes through a two-entry queue. Histogram entries are cleared at once by valid bits.
module windowed_byte_entropy #(
  parameter int MAX_BLOCK     = 65536,
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  wbe_pkg::in_req_t          in_req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output wbe_pkg::out_req_t         out_req,
  input  logic                      cfg_we,
  input  logic [wbe_pkg::CFG_W-1:0] cfg_wdata
);
  import wbe_pkg::*;

  localparam int CW = $clog2(MAX_BLOCK + 1);
  localparam int LW = $clog2(CW) + QF;
  localparam int WW = CW + LW;
  localparam int QW = WW + CW + 1;

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  wbe_front #(.MAX_BLOCK(MAX_BLOCK), .CW(CW), .WW(WW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  wbe_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  wbe_back #(.CW(CW), .WW(WW), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_rdata   (q_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

endmodule

@@ hdl/wbe_checker.sv @@
// Port-level checks of the windowed byte entropy block, bound to the top level.
// Depends on wbe_pkg and windowed_byte_entropy_macros.svh.
`include "windowed_byte_entropy_macros.svh"

module wbe_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input wbe_pkg::out_req_t out_req
);
  import wbe_pkg::*;

  `WBE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_req))
  `WBE_ASSERT_ALWAYS_NEXT(a_reset_quiet, clk, !rst_n, !out_valid)
  `WBE_ASSERT_NEXT(a_one_byte, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

bind windowed_byte_entropy wbe_checker u_wbe_checker (.*);
